FILE: sv/fdaf_pkg.sv
// Shared types and constants for the fixed-point decimal to ASCII formatter.
// No dependencies; used by the front, queue, back and top-level modules.
package fdaf_pkg;

  // Input and conversion widths
  localparam int unsigned ValueWidth = 25;
  localparam int unsigned MagWidth   = 24;
  localparam int unsigned NumDigits  = 7;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned BitsPerStep = 3;
  localparam int unsigned NumSteps   = MagWidth / BitsPerStep;
  localparam int unsigned StepWidth  = $clog2(NumSteps);

  // Saturation limit: 999.9999 in ten-thousandths
  localparam logic [ValueWidth-1:0] MAG_LIMIT = 25'd9999999;

  // Fraction digit count register
  localparam int unsigned CfgWidth = 3;
  localparam logic [CfgWidth-1:0] CFG_RESET = 3'd4;
  localparam logic [CfgWidth-1:0] CFG_MIN   = 3'd1;
  localparam logic [CfgWidth-1:0] CFG_MAX   = 3'd4;

  // Character codes
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;

  // Digit positions in the BCD word
  localparam logic [2:0] DIG_HUND  = 3'd6;
  localparam logic [2:0] DIG_TENS  = 3'd5;
  localparam logic [2:0] DIG_UNITS = 3'd4;
  localparam logic [2:0] DIG_FRAC0 = 3'd3;

  // One converted value, handed from front to back
  typedef struct packed {
    logic                      neg;
    logic [NumDigits-1:0][3:0] digits;     // [6] hundreds ... [0] last fraction digit
    logic [1:0]                frac_last;  // fraction digits shown minus one
  } entry_t;

endpackage

FILE: sv/fdaf_front.sv
// Front end: accepts values, takes magnitude with saturation and converts to BCD.
// Holds the fraction digit count register. Depends on fdaf_pkg.
module fdaf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fdaf_pkg::ValueWidth-1:0]     value_ten_thousandths_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fdaf_pkg::CfgWidth-1:0]       cfg_data_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output fdaf_pkg::entry_t                    push_data_o
);

  localparam int unsigned ShiftWidth = fdaf_pkg::BcdWidth + fdaf_pkg::MagWidth;

  // Three shift-and-correct iterations of double dabble
  function automatic logic [ShiftWidth-1:0] dd_step(logic [ShiftWidth-1:0] v);
    logic [ShiftWidth-1:0] w;
    w = v;
    for (int s = 0; s < fdaf_pkg::BitsPerStep; s++) begin
      for (int k = 0; k < fdaf_pkg::NumDigits; k++) begin
        if (w[fdaf_pkg::MagWidth + 4*k +: 4] >= 4'd5) begin
          w[fdaf_pkg::MagWidth + 4*k +: 4] = w[fdaf_pkg::MagWidth + 4*k +: 4] + 4'd3;
        end
      end
      w = {w[ShiftWidth-2:0], 1'b0};
    end
    return w;
  endfunction

  logic [fdaf_pkg::CfgWidth-1:0]  cfg_q;
  logic                           busy_q, done_q, neg_q;
  logic [fdaf_pkg::StepWidth-1:0] step_q;
  logic [ShiftWidth-1:0]          sh_q, sh_step;
  logic [1:0]                     frac_last_q, frac_last_d;
  logic                           in_acc, push_fire;
  logic                           neg_in;
  logic [fdaf_pkg::ValueWidth-1:0] mag_full;
  logic [fdaf_pkg::MagWidth-1:0]   mag_sat;

  assign cfg_ready_o = 1'b1;

  // Write the fraction digit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= fdaf_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Clamp the digit count to 1..4 and keep it as count minus one
  always_comb begin
    if (cfg_q < fdaf_pkg::CFG_MIN) begin
      frac_last_d = 2'd0;
    end else if (cfg_q > fdaf_pkg::CFG_MAX) begin
      frac_last_d = 2'd3;
    end else begin
      frac_last_d = 2'(cfg_q - 3'd1);
    end
  end

  // Magnitude with saturation at 999.9999
  assign neg_in   = value_ten_thousandths_i[fdaf_pkg::ValueWidth-1];
  assign mag_full = neg_in ? (~value_ten_thousandths_i + 25'd1) : value_ten_thousandths_i;
  assign mag_sat  = (mag_full > fdaf_pkg::MAG_LIMIT) ?
                    fdaf_pkg::MAG_LIMIT[fdaf_pkg::MagWidth-1:0] :
                    mag_full[fdaf_pkg::MagWidth-1:0];

  // Handshake: accept a new item when idle or when the finished one leaves
  assign push_fire  = done_q && push_ready_i;
  assign in_stall_o = busy_q && !push_fire;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sh_step    = dd_step(sh_q);

  // Control: load, step the converter, hand off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (push_fire) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (busy_q && !done_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == fdaf_pkg::StepWidth'(fdaf_pkg::NumSteps - 1)) begin
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: shift register and item fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sh_q        <= {{fdaf_pkg::BcdWidth{1'b0}}, mag_sat};
      neg_q       <= neg_in;
      frac_last_q <= frac_last_d;
    end else if (busy_q && !done_q) begin
      sh_q <= sh_step;
    end
  end

  assign push_valid_o          = done_q;
  assign push_data_o.neg       = neg_q;
  assign push_data_o.digits    = sh_q[ShiftWidth-1:fdaf_pkg::MagWidth];
  assign push_data_o.frac_last = frac_last_q;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> busy_q) else $error("conversion done without a busy item");
  a_done_shifted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (sh_q[fdaf_pkg::MagWidth-1:0] == '0 && step_q == '0))
    else $error("binary bits left after conversion");
  a_bcd_digits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (push_data_o.digits[fdaf_pkg::DIG_HUND] <= 4'd9 &&
                push_data_o.digits[fdaf_pkg::DIG_FRAC0] <= 4'd9))
    else $error("BCD digit out of range");

endmodule

FILE: sv/fdaf_queue.sv
// Two-entry queue between the converter front end and the character back end.
// Depends on fdaf_pkg for the entry type.
module fdaf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  fdaf_pkg::entry_t push_data_i,
  output logic             head_valid_o,
  output fdaf_pkg::entry_t head_data_o,
  input  logic             pop_i
);

  fdaf_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_data_o  = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count overflow");
  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
  a_push_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not grow on push");

endmodule

FILE: sv/fdaf_back.sv
// Back end: walks the head entry and emits one ASCII character per cycle while not stalled.
// Drives the registered output channel. Depends on fdaf_pkg.
module fdaf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  fdaf_pkg::entry_t head_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       char_code_o,
  output logic             last_char_o
);

  typedef enum logic [5:0] {
    ST_SIGN  = 6'b000001,
    ST_HUND  = 6'b000010,
    ST_TENS  = 6'b000100,
    ST_UNITS = 6'b001000,
    ST_DOT   = 6'b010000,
    ST_FRAC  = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, last_q;
  logic [7:0]  char_q, char_d;
  logic        load_ok, emit, is_last;
  logic [2:0]  frac_sel;
  logic [3:0]  hund, tens, units;

  assign hund     = head_data_i.digits[fdaf_pkg::DIG_HUND];
  assign tens     = head_data_i.digits[fdaf_pkg::DIG_TENS];
  assign units    = head_data_i.digits[fdaf_pkg::DIG_UNITS];
  assign frac_sel = fdaf_pkg::DIG_FRAC0 - {1'b0, idx_q};

  assign load_ok = !out_valid_q || !out_stall_i;
  assign emit    = head_valid_i && load_ok;
  assign is_last = (state_q == ST_FRAC) && (idx_q == head_data_i.frac_last);
  assign pop_o   = emit && is_last;

  // Select the character and the next position
  always_comb begin
    char_d  = fdaf_pkg::CHAR_DOT;
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_SIGN: begin
        char_d = head_data_i.neg ? fdaf_pkg::CHAR_MINUS : fdaf_pkg::CHAR_PLUS;
        if (hund != 4'd0) begin
          state_d = ST_HUND;
        end else if (tens != 4'd0) begin
          state_d = ST_TENS;
        end else begin
          state_d = ST_UNITS;
        end
      end
      ST_HUND: begin
        char_d  = fdaf_pkg::DIGIT_BASE | {4'd0, hund};
        state_d = ST_TENS;
      end
      ST_TENS: begin
        char_d  = fdaf_pkg::DIGIT_BASE | {4'd0, tens};
        state_d = ST_UNITS;
      end
      ST_UNITS: begin
        char_d  = fdaf_pkg::DIGIT_BASE | {4'd0, units};
        state_d = ST_DOT;
      end
      ST_DOT: begin
        char_d  = fdaf_pkg::CHAR_DOT;
        state_d = ST_FRAC;
        idx_d   = 2'd0;
      end
      ST_FRAC: begin
        char_d = fdaf_pkg::DIGIT_BASE | {4'd0, head_data_i.digits[frac_sel]};
        if (is_last) begin
          state_d = ST_SIGN;
          idx_d   = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      default: begin
        state_d = ST_SIGN;
        idx_d   = 2'd0;
      end
    endcase
  end

  // Advance position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SIGN;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else if (emit) begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the output character
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  a_idx_frac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FRAC) |-> (idx_q == 2'd0)) else $error("fraction index off outside fraction");
  a_sign_char : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && state_q == ST_SIGN) |=>
      (out_valid_o && (char_code_o == fdaf_pkg::CHAR_MINUS || char_code_o == fdaf_pkg::CHAR_PLUS)))
    else $error("first character is not a sign");
  a_last_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_SIGN && out_valid_o && last_char_o))
    else $error("last character did not restart the sequence");

endmodule

FILE: sv/fixed_decimal_ascii_formatter.sv
// Top level of the fixed-point decimal to ASCII formatter.
// Connects fdaf_front, fdaf_queue and fdaf_back; depends on fdaf_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o value_ten_thousandths_i [24:0] signed
//   out      output     out_valid_o/out_stall_i char_code_o [7:0], last_char_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i [2:0] fraction digit count
//
// The front converter runs 8 double-dabble steps of 3 bits each, then hands the item
// into the queue; it takes a new item only when idle or as its finished item leaves.
// The back end emits 4 to 9 characters per item, one per cycle while not stalled.
// Reset is asynchronous, active low, and sets the digit count to 4. Either side may
// stall; the two-entry queue and the output register keep front and back running
// independently.
module fixed_decimal_ascii_formatter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fdaf_pkg::ValueWidth-1:0] value_ten_thousandths_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      char_code_o,
  output logic                            last_char_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fdaf_pkg::CfgWidth-1:0]   cfg_data_i
);

  logic             push_valid, push_ready, head_valid, pop;
  fdaf_pkg::entry_t push_data, head_data;

  // Accept and convert
  fdaf_front u_front (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .value_ten_thousandths_i (value_ten_thousandths_i),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_data_i              (cfg_data_i),
    .push_valid_o            (push_valid),
    .push_ready_i            (push_ready),
    .push_data_o             (push_data)
  );

  // Buffer converted items
  fdaf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  // Emit characters
  fdaf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

endmodule

FILE: tb/tb_fixed_decimal_ascii_formatter.sv
// Self-checking testbench for fixed_decimal_ascii_formatter: a directed table, then random
// values under three sender/receiver stall mixes, each character checked against a predictor.
// Depends on fdaf_pkg and the formatter RTL only.
module tb_fixed_decimal_ascii_formatter;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 16;
  localparam int ITEMS_PHASE  = 26;
  localparam int NO_CFG       = -1;
  localparam int NUM_DIRECTED = 22;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  typedef struct {
    int    cfg_before;  // digit count written before the value, or NO_CFG
    int    value;
    string text;        // hand-written text; empty means use the predictor
  } dir_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [fdaf_pkg::ValueWidth-1:0] value_ten_thousandths_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [7:0]                      char_code_o;
  logic                            last_char_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [fdaf_pkg::CfgWidth-1:0]   cfg_data_i = '0;

  text_char_t                    expected_text[$];
  text_char_t                    next_char;
  logic [fdaf_pkg::CfgWidth-1:0] frac_digits_shadow = fdaf_pkg::CFG_RESET;
  int                            sender_idle_pct = 0;
  int                            receiver_idle_pct = 0;
  int                            error_count = 0;
  int                            cycle_count = 0;
  int                            values_sent = 0;
  int                            chars_checked = 0;
  int                            cfg_writes = 0;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{NO_CFG,  0,         "+0.0000"},
    '{NO_CFG,  9999999,   "+999.9999"},
    '{NO_CFG,  -9999999,  "-999.9999"},
    '{NO_CFG,  10000000,  "+999.9999"},
    '{NO_CFG,  16777215,  "+999.9999"},
    '{NO_CFG,  -16777216, "-999.9999"},
    '{NO_CFG,  -1,        "-0.0001"},
    '{NO_CFG,  1000000,   "+100.0000"},
    '{NO_CFG,  100000,    "+10.0000"},
    '{NO_CFG,  123456,    "+12.3456"},
    '{1,       -1,        "-0.0"},
    '{NO_CFG,  9999999,   "+999.9"},
    '{NO_CFG,  1234567,   "+123.4"},
    '{0,       54321,     "+5.4"},
    '{2,       -50,       "-0.00"},
    '{NO_CFG,  314159,    "+31.41"},
    '{3,       27182,     ""},
    '{5,       7,         "+0.0007"},
    '{6,       4200,      "+0.4200"},
    '{7,       -12345,    "-1.2345"},
    '{4,       5592405,   ""},
    '{NO_CFG,  -8388608,  ""}
  };

  fixed_decimal_ascii_formatter dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .value_ten_thousandths_i(value_ten_thousandths_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .char_code_o            (char_code_o),
    .last_char_o            (last_char_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_data_i             (cfg_data_i)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters pending", cycle_count,
               expected_text.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
             want);
  endtask

  // Append the characters of one value's text to the expected store
  function automatic void push_formatted_text(input logic [fdaf_pkg::ValueWidth-1:0] raw,
                                              input logic [fdaf_pkg::CfgWidth-1:0] digit_cfg);
    text_char_t                      chars[$];
    logic                            neg;
    logic [fdaf_pkg::ValueWidth-1:0] mag;
    int unsigned                     ipart, fpart, hund, tens, units, shown;
    int unsigned                     frac[4];
    neg = raw[fdaf_pkg::ValueWidth-1];
    mag = neg ? -raw : raw;
    if (mag > fdaf_pkg::MAG_LIMIT) mag = fdaf_pkg::MAG_LIMIT;
    ipart = int'(mag) / 10000;
    fpart = int'(mag) % 10000;
    hund  = ipart / 100;
    tens  = (ipart % 100) / 10;
    units = ipart % 10;
    frac[0] = fpart / 1000;
    frac[1] = (fpart % 1000) / 100;
    frac[2] = (fpart % 100) / 10;
    frac[3] = fpart % 10;
    shown = digit_cfg;
    if (shown < fdaf_pkg::CFG_MIN) shown = fdaf_pkg::CFG_MIN;
    if (shown > fdaf_pkg::CFG_MAX) shown = fdaf_pkg::CFG_MAX;
    chars.push_back(text_char_t'{neg ? fdaf_pkg::CHAR_MINUS : fdaf_pkg::CHAR_PLUS, 1'b0});
    if (hund != 0) chars.push_back(text_char_t'{fdaf_pkg::DIGIT_BASE | 8'(hund), 1'b0});
    if (hund != 0 || tens != 0)
      chars.push_back(text_char_t'{fdaf_pkg::DIGIT_BASE | 8'(tens), 1'b0});
    chars.push_back(text_char_t'{fdaf_pkg::DIGIT_BASE | 8'(units), 1'b0});
    chars.push_back(text_char_t'{fdaf_pkg::CHAR_DOT, 1'b0});
    for (int i = 0; i < int'(shown); i++)
      chars.push_back(text_char_t'{fdaf_pkg::DIGIT_BASE | 8'(frac[i]), 1'b0});
    chars[chars.size()-1].last = 1'b1;
    foreach (chars[i]) expected_text.push_back(chars[i]);
  endfunction

  // Offer one item; record its expected text once accepted
  task automatic send_value(input logic [fdaf_pkg::ValueWidth-1:0] value, input string text);
    int gap;
    bit accepted;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_ten_thousandths_i <= value;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = in_valid_i && !in_stall_o;
    end
    if (text.len() == 0) begin
      push_formatted_text(value, frac_digits_shadow);
    end else begin
      for (int i = 0; i < text.len(); i++)
        expected_text.push_back(text_char_t'{text[i], 1'(i == text.len() - 1)});
    end
    values_sent++;
  endtask

  // Hold off input until every pending character has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_digit_count(input logic [fdaf_pkg::CfgWidth-1:0] count);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frac_digits_shadow = count;
    cfg_writes++;
  endtask

  // Mix of in-range, saturating, tiny and digit-boundary values
  function automatic logic [fdaf_pkg::ValueWidth-1:0] random_value();
    logic [fdaf_pkg::ValueWidth-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = fdaf_pkg::ValueWidth'($urandom_range(9999999));
      4, 5:       v = fdaf_pkg::ValueWidth'($urandom);
      6:          v = fdaf_pkg::ValueWidth'($urandom_range(19999));
      7:          v = fdaf_pkg::ValueWidth'($urandom_range(999) * 10000 + $urandom_range(2));
      8:          v = fdaf_pkg::ValueWidth'($urandom_range(10000010, 9999990));
      default:    v = fdaf_pkg::ValueWidth'($urandom_range(999999, 10000));
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  // Randomly stall the character stream
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_text.size() == 0) begin
        report_mismatch("character with nothing pending", char_code_o, 0);
      end else begin
        next_char = expected_text.pop_front();
        if (char_code_o !== next_char.code)
          report_mismatch("char_code", char_code_o, next_char.code);
        if (last_char_o !== next_char.last)
          report_mismatch("last_char", last_char_o, next_char.last);
      end
      chars_checked++;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    sender_idle_pct = 20;
    receiver_idle_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_before != NO_CFG)
        write_digit_count(fdaf_pkg::CfgWidth'(directed_rows[i].cfg_before));
      send_value(fdaf_pkg::ValueWidth'(directed_rows[i].value), directed_rows[i].text);
    end

    // Random values: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 30 : (phase == 1) ? 85 : 0;
      receiver_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 30 : 0;
      write_digit_count((phase == 0) ? fdaf_pkg::CFG_MIN :
                        (phase == 1) ? fdaf_pkg::CFG_MAX : 3'd0);
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        if (n % 12 == 11) write_digit_count(fdaf_pkg::CfgWidth'($urandom_range(7)));
        send_value(random_value(), "");
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (expected_text.size() != 0)
      report_mismatch("characters never emitted", 0, expected_text.size());
    $display("summary: %0d values formatted, %0d characters compared, %0d digit-count writes",
             values_sent, chars_checked, cfg_writes);
    $display("summary: counts 0 to 7 set, stall mixes 30/85, 85/30 and none, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
